### design/emp_pkg.sv
package emp_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int TIMER_BITS_DEF = 16;

  typedef enum logic [1:0] {
    CMD_FALL   = 2'd0,
    CMD_RISE   = 2'd1,
    CMD_RELOAD = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PPR   = 2'd0,
    REG_SCALE = 2'd1,
    REG_REV   = 2'd2,
    REG_CHANS = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    DIR_NONE     = 2'd0,
    DIR_FORWARD  = 2'd1,
    DIR_BACKWARD = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic [15:0] ppr;
    logic [31:0] scale;
    logic [3:0]  rev;
    logic [2:0]  chans;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        active;
    logic [1:0]  channel;
    logic        b_level;
    logic [15:0] timer_now;
    logic [15:0] edge_capture;
  } item_t;

endpackage

### design/emp_front.sv
module emp_front import emp_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [1:0]  channel,
  input  logic        b_level,
  input  logic [15:0] timer_now,
  input  logic [15:0] edge_capture,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  item_t       item_in;

  always_comb begin
    item_in.cmd          = cmd_t'(cmd);
    item_in.active       = ({1'b0, channel} < cfg.chans) && (32'(channel) < CHANNELS);
    item_in.channel      = channel;
    item_in.b_level      = b_level;
    item_in.timer_now    = timer_now;
    item_in.edge_capture = edge_capture;
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= item_in;
  end

endmodule

### design/emp_back.sv
module emp_back import emp_pkg::*; #(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_channel,
  output logic signed [31:0] speed_rpm,
  output logic signed [31:0] edge_total,
  output logic               edge_flag
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [31:0] TMASK =
    (TIMER_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TIMER_BITS) - 32'd1);

  logic [31:0] window_count   [CHANNELS];
  logic        edge_seen      [CHANNELS];
  logic [15:0] first_stamp    [CHANNELS];
  logic [15:0] last_stamp     [CHANNELS];
  dir_t        last_direction [CHANNELS];
  logic [15:0] capture_period [CHANNELS];
  logic [15:0] wrap_count     [CHANNELS];
  logic [31:0] last_abs_time  [CHANNELS];

  back_state_t state;
  back_state_t state_next;
  logic        load_out;

  logic [1:0]  res_channel;
  logic [31:0] res_total;
  logic        res_had;
  logic        res_neg;
  logic        res_zero;
  logic [31:0] mag_m;
  logic [32:0] t_reg;
  logic [63:0] num;
  logic [48:0] den;
  logic [48:0] rem;
  logic [5:0]  cnt;

  logic [IDX_W-1:0] idx;
  logic [15:0] stamp;
  logic [31:0] now_abs;
  logic [31:0] since;
  logic        fwd;
  logic        up;
  logic [31:0] wc;
  logic        m_neg;
  logic [31:0] m_mag;
  logic [31:0] span;
  logic [32:0] t_sel;
  logic [31:0] per;
  logic        zero_sel;
  logic        neg_sel;
  logic [31:0] mag_sel;
  logic [49:0] trial;
  logic [31:0] sat;

  function automatic logic [31:0] abs_time(input logic [15:0] wrap, input logic [15:0] stmp);
    logic [63:0] w;
    w = {48'd0, wrap} << TIMER_BITS;
    return w[31:0] | {16'd0, stmp};
  endfunction

  always_comb begin
    idx     = IDX_W'(q_item.channel);
    stamp   = q_item.timer_now & TMASK[15:0];
    now_abs = abs_time(wrap_count[idx], stamp);
    since   = now_abs - last_abs_time[idx];
    fwd     = (q_item.cmd == CMD_FALL) ? q_item.b_level : !q_item.b_level;
    up      = fwd ^ cfg.rev[q_item.channel];
    wc      = window_count[idx];
    m_neg   = wc[31];
    m_mag   = m_neg ? (32'd0 - wc) : wc;
    span    = ({16'd0, last_stamp[idx]} - {16'd0, first_stamp[idx]}) & TMASK;
    per     = (capture_period[idx] == 16'd0) ? 32'd1 : {16'd0, capture_period[idx]};
    zero_sel = (cfg.ppr == 16'd0);
    neg_sel  = m_neg;
    mag_sel  = m_mag;
    if (m_mag >= 32'd2) begin
      t_sel = (span == 32'd0) ? (33'd1 << TIMER_BITS) : {1'b0, span};
    end else if (m_mag == 32'd1) begin
      if (capture_period[idx] != 16'd0) t_sel = {17'd0, capture_period[idx]};
      else t_sel = (since == 32'd0) ? 33'd1 : {1'b0, since};
    end else begin
      t_sel   = (since > per) ? {1'b0, since} : {1'b0, per};
      mag_sel = 32'd1;
      neg_sel = (last_direction[idx] == DIR_BACKWARD);
      if (last_direction[idx] == DIR_NONE) zero_sel = 1'b1;
    end
    trial = {rem, num[63]};
    if (num > 64'h0000_0000_7FFF_FFFF) sat = res_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else sat = res_neg ? (32'd0 - num[31:0]) : num[31:0];
    if (res_neg && num == 64'h0000_0000_8000_0000) sat = 32'h8000_0000;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && q_item.cmd == CMD_SAMPLE) begin
          if (!q_item.active || zero_sel) state_next = ST_DONE;
          else state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (cnt == 6'd0) state_next = ST_DONE;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: q_pop    = q_valid;
      ST_DONE: load_out = !out_valid || !out_stall;
      default: begin
        q_pop    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        window_count[i]   <= 32'd0;
        edge_seen[i]      <= 1'b0;
        first_stamp[i]    <= 16'd0;
        last_stamp[i]     <= 16'd0;
        last_direction[i] <= DIR_NONE;
        capture_period[i] <= 16'd0;
        wrap_count[i]     <= 16'd0;
        last_abs_time[i]  <= 32'd0;
      end
    end else if (q_pop && q_item.active) begin
      case (q_item.cmd)
        CMD_FALL, CMD_RISE: begin
          window_count[idx] <= wc + (up ? 32'd1 : 32'hFFFF_FFFF);
          if (!edge_seen[idx]) first_stamp[idx] <= stamp;
          edge_seen[idx]      <= 1'b1;
          last_stamp[idx]     <= stamp;
          last_abs_time[idx]  <= now_abs;
          last_direction[idx] <= fwd ? DIR_FORWARD : DIR_BACKWARD;
          if (q_item.cmd == CMD_RISE) capture_period[idx] <= q_item.edge_capture;
        end
        CMD_RELOAD: wrap_count[idx] <= wrap_count[idx] + 16'd1;
        CMD_SAMPLE: begin
          window_count[idx] <= 32'd0;
          edge_seen[idx]    <= 1'b0;
        end
        default: window_count[idx] <= wc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        res_channel <= q_item.channel;
        res_total   <= q_item.active ? wc : 32'd0;
        res_had     <= q_item.active && edge_seen[idx];
        res_zero    <= !q_item.active || zero_sel;
        res_neg     <= neg_sel;
        mag_m       <= mag_sel;
        t_reg       <= t_sel;
      end
      ST_MUL: begin
        num <= 64'(mag_m) * 64'(cfg.scale);
        den <= 49'(t_reg) * 49'(cfg.ppr);
        rem <= 49'd0;
        cnt <= 6'd63;
      end
      ST_DIV: begin
        cnt <= cnt - 6'd1;
        if (trial >= {1'b0, den}) begin
          rem <= 49'(trial - {1'b0, den});
          num <= {num[62:0], 1'b1};
        end else begin
          rem <= trial[48:0];
          num <= {num[62:0], 1'b0};
        end
      end
      default: cnt <= cnt;
    endcase
    if (load_out) begin
      out_channel <= res_channel;
      edge_total  <= res_total;
      edge_flag   <= res_had;
      speed_rpm   <= res_zero ? 32'd0 : sat;
    end
  end

endmodule

### design/encoder_mt_speed_meter.sv
// Channel   Handshake             Payload
// in        in_valid / in_stall   cmd, channel, b_level, timer_now, edge_capture
// out       out_valid / out_stall out_channel, speed_rpm, edge_total, edge_flag
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// An edge or reload item passes a two-item input queue and is applied in the idle state.
// A window sample passes through a capture step, a multiply step, the bit-serial divider
// and an output load step; an inactive channel or a zero PPR skips straight to the load.
// Reset is synchronous and returns channel state, control and config registers to defaults.
// A stalled output holds its item while the queue keeps taking input until it is full.
module encoder_mt_speed_meter import emp_pkg::*; #(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [1:0]         channel,
  input  logic               b_level,
  input  logic [15:0]        timer_now,
  input  logic [15:0]        edge_capture,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_channel,
  output logic signed [31:0] speed_rpm,
  output logic signed [31:0] edge_total,
  output logic               edge_flag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ppr   <= 16'd1;
      cfg.scale <= 32'd60000000;
      cfg.rev   <= 4'd0;
      cfg.chans <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_PPR:   cfg.ppr   <= cfg_data[15:0];
        REG_SCALE: cfg.scale <= cfg_data;
        REG_REV:   cfg.rev   <= cfg_data[3:0];
        REG_CHANS: cfg.chans <= cfg_data[2:0];
        default:   cfg.ppr   <= cfg.ppr;
      endcase
    end
  end

  emp_front #(.CHANNELS(CHANNELS)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .channel(channel), .b_level(b_level),
    .timer_now(timer_now), .edge_capture(edge_capture),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  emp_back #(.CHANNELS(CHANNELS), .TIMER_BITS(TIMER_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_channel(out_channel), .speed_rpm(speed_rpm),
    .edge_total(edge_total), .edge_flag(edge_flag)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import emp_pkg::*;

  typedef struct {
    cmd_t        op;
    logic [1:0]  ch;
    logic        b;
    logic [15:0] stamp;
    logic [15:0] cap;
  } event_t;

  typedef struct {
    logic [1:0]         ch;
    logic signed [31:0] rpm;
    logic signed [31:0] count;
    logic               seen;
  } speed_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = CMD_FALL;
  logic [1:0]         channel = 2'd0;
  logic               b_level = 1'b0;
  logic [15:0]        timer_now = 16'd0;
  logic [15:0]        edge_capture = 16'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_channel;
  logic signed [31:0] speed_rpm;
  logic signed [31:0] edge_total;
  logic               edge_flag;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_PPR;
  logic [31:0]        cfg_data = 32'd0;

  encoder_mt_speed_meter DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state.
  logic [15:0] ppr;
  logic [31:0] scale;
  logic [3:0]  rev;
  logic [2:0]  chans;
  logic [31:0] m_count [4];
  logic        seen [4];
  logic [15:0] first_t [4];
  logic [15:0] last_t [4];
  dir_t        prev_dir [4];
  logic [15:0] period [4];
  logic [15:0] wraps [4];
  logic [31:0] prev_abs [4];

  event_t pending_events [$];
  speed_t expected_speeds [$];
  int     failures = 0;
  bit     steady = 1'b0;
  bit     want_hold = 1'b0;
  bit     hold_done = 1'b0;
  int     hold_cnt = 0;
  int     quiet = 0;
  logic [15:0] clock_of [4];

  function automatic logic signed [31:0] rpm_of(longint m, longint t);
    longint q;
    if (ppr == 0 || t == 0) return 0;
    q = (m * longint'(scale)) / (t * longint'(ppr));
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic void predict_event(event_t e);
    bit     on;
    bit     fwd;
    speed_t r;
    longint m;
    longint t;
    logic [31:0] since;
    logic [31:0] per;
    logic [15:0] span;
    on = e.ch < chans;
    if (e.op == CMD_FALL || e.op == CMD_RISE) begin
      if (!on) return;
      fwd = (e.op == CMD_FALL) ? e.b : !e.b;
      m_count[e.ch] += (fwd ^ rev[e.ch]) ? 32'd1 : 32'hFFFF_FFFF;
      if (!seen[e.ch]) begin
        first_t[e.ch] = e.stamp;
        seen[e.ch] = 1'b1;
      end
      last_t[e.ch] = e.stamp;
      prev_abs[e.ch] = {wraps[e.ch], e.stamp};
      prev_dir[e.ch] = fwd ? DIR_FORWARD : DIR_BACKWARD;
      if (e.op == CMD_RISE) period[e.ch] = e.cap;
      return;
    end
    if (e.op == CMD_RELOAD) begin
      if (on) wraps[e.ch] += 16'd1;
      return;
    end
    r.ch = e.ch;
    r.rpm = 0;
    r.count = 0;
    r.seen = 1'b0;
    if (on) begin
      m = longint'(signed'(m_count[e.ch]));
      since = {wraps[e.ch], e.stamp} - prev_abs[e.ch];
      r.count = m_count[e.ch];
      r.seen = seen[e.ch];
      m_count[e.ch] = 0;
      seen[e.ch] = 1'b0;
      if (m >= 2 || m <= -2) begin
        span = last_t[e.ch] - first_t[e.ch];
        t = longint'(span);
        if (t == 0) t = 65536;
        r.rpm = rpm_of(m, t);
      end else if (m != 0) begin
        t = period[e.ch];
        if (t == 0) t = (since == 0) ? 1 : longint'(since);
        r.rpm = rpm_of(m, t);
      end else if (prev_dir[e.ch] != DIR_NONE) begin
        per = (period[e.ch] == 0) ? 32'd1 : {16'd0, period[e.ch]};
        t = (since > per) ? since : per;
        r.rpm = rpm_of((prev_dir[e.ch] == DIR_FORWARD) ? 1 : -1, t);
      end
    end
    expected_speeds.push_back(r);
  endfunction

  always @(posedge clk) begin
    event_t e;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        e.op = cmd_t'(cmd);
        e.ch = channel;
        e.b = b_level;
        e.stamp = timer_now;
        e.cap = edge_capture;
        predict_event(e);
      end
      if (pending_events.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
        e = pending_events.pop_front();
        in_valid <= 1'b1;
        cmd <= e.op;
        channel <= e.ch;
        b_level <= e.b;
        timer_now <= e.stamp;
        edge_capture <= e.cap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    speed_t x;
    if (!rst && out_valid && !out_stall) begin
      if (expected_speeds.size() == 0) begin
        $error("Unexpected result for channel %0d", out_channel);
        failures++;
      end else begin
        x = expected_speeds.pop_front();
        if (out_channel !== x.ch) begin
          $error("out_channel: expected %0d, got %0d", x.ch, out_channel);
          failures++;
        end
        if (speed_rpm !== x.rpm) begin
          $error("speed_rpm: expected %0d, got %0d", x.rpm, speed_rpm);
          failures++;
        end
        if (edge_total !== x.count) begin
          $error("edge_total: expected %0d, got %0d", x.count, edge_total);
          failures++;
        end
        if (edge_flag !== x.seen) begin
          $error("edge_flag: expected %0d, got %0d", x.seen, edge_flag);
          failures++;
        end
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (want_hold && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 33);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= 3000) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PPR:   ppr = data[15:0];
      REG_SCALE: scale = data;
      REG_REV:   rev = data[3:0];
      REG_CHANS: chans = data[2:0];
      default:   ppr = ppr;
    endcase
  endtask

  task automatic settle();
    wait (pending_events.size() == 0 && expected_speeds.size() == 0 && !in_valid);
    repeat (80) @(posedge clk);
  endtask

  task automatic add(cmd_t op, int ch, int b, int stamp, int cap);
    event_t e;
    e.op = op;
    e.ch = 2'(ch);
    e.b = 1'(b);
    e.stamp = 16'(stamp);
    e.cap = 16'(cap);
    pending_events.push_back(e);
  endtask

  // Mostly complete windows on one channel: a run of edges, with reloads
  // mixed in, closed by a sample. The rest is unstructured traffic.
  task automatic add_random(int n);
    int ch;
    int k;
    bit dir;
    cmd_t op;
    while (n > 0) begin
      ch = $urandom_range(3);
      if ($urandom_range(99) < 80) begin
        k = $urandom_range(6);
        dir = 1'($urandom_range(1));
        repeat (k) begin
          clock_of[ch] += 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(400));
          if ($urandom_range(9) == 0) begin
            add(CMD_RELOAD, ch, $urandom_range(1), $urandom, $urandom);
          end else begin
            op = $urandom_range(1) ? CMD_RISE : CMD_FALL;
            add(op, ch, ($urandom_range(7) == 0) ^ ((op == CMD_FALL) ? dir : !dir),
                clock_of[ch], $urandom_range(3) == 0 ? 0 : $urandom);
          end
        end
        clock_of[ch] += 16'($urandom_range(2000));
        add(CMD_SAMPLE, ch, $urandom_range(1), clock_of[ch], $urandom);
        n -= k + 1;
      end else begin
        add(cmd_t'($urandom_range(3)), ch, $urandom_range(1), $urandom, $urandom);
        n--;
      end
    end
  endtask

  initial begin
    ppr = 16'd1;
    scale = 32'd60000000;
    rev = 4'd0;
    chans = 3'd4;
    for (int i = 0; i < 4; i++) begin
      m_count[i] = 0;
      seen[i] = 0;
      first_t[i] = 0;
      last_t[i] = 0;
      prev_dir[i] = DIR_NONE;
      period[i] = 0;
      wraps[i] = 0;
      prev_abs[i] = 0;
      clock_of[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    add(CMD_SAMPLE, 3, 0, 16'h0000, 16'h0000);
    add(CMD_FALL, 0, 1, 100, 16'hFFFF);
    add(CMD_RISE, 0, 0, 300, 50);
    add(CMD_SAMPLE, 0, 1, 400, 0);
    add(CMD_SAMPLE, 0, 0, 16'hFFFF, 0);
    add(CMD_RISE, 1, 1, 16'hFFFF, 0);
    add(CMD_SAMPLE, 1, 0, 16'hFFFF, 0);
    add(CMD_FALL, 2, 1, 5, 0);
    add(CMD_FALL, 2, 1, 5, 0);
    add(CMD_SAMPLE, 2, 0, 9, 0);
    add(CMD_RELOAD, 3, 1, 16'hFFFF, 16'hFFFF);
    add(CMD_RELOAD, 3, 0, 0, 0);
    add(CMD_RISE, 3, 0, 16'hFFFF, 16'hFFFF);
    add(CMD_SAMPLE, 3, 1, 16'h0000, 16'hFFFF);
    add(CMD_SAMPLE, 2, 1, 7, 0);
    settle();

    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_REV, 32'hF);
    write_reg(REG_PPR, 1);
    add(CMD_FALL, 0, 1, 10, 0);
    add(CMD_FALL, 0, 1, 11, 0);
    add(CMD_RISE, 1, 1, 20, 1);
    add(CMD_RISE, 1, 1, 21, 1);
    add(CMD_SAMPLE, 0, 0, 12, 0);
    add(CMD_SAMPLE, 1, 0, 22, 0);
    settle();

    write_reg(REG_CHANS, 2);
    write_reg(REG_PPR, 0);
    add(CMD_FALL, 3, 1, 1, 0);
    add(CMD_RELOAD, 3, 0, 1, 0);
    add(CMD_SAMPLE, 3, 0, 2, 0);
    add(CMD_FALL, 0, 1, 3, 0);
    add(CMD_SAMPLE, 0, 0, 4, 0);
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_reg(REG_PPR, 16'hFFFF);
        1: write_reg(REG_PPR, $urandom_range(1, 64));
        2: write_reg(REG_PPR, 1);
        default: write_reg(REG_PPR, $urandom_range(16'hFFFF));
      endcase
      case (ph)
        0: write_reg(REG_SCALE, 1);
        3: write_reg(REG_SCALE, 32'hFFFF_FFFF);
        default: write_reg(REG_SCALE, $urandom_range(3) == 0 ? 60000000 : $urandom);
      endcase
      write_reg(REG_REV, $urandom_range(15));
      write_reg(REG_CHANS, ph < 3 ? 4 : $urandom_range(7));
      steady = (ph == 2);
      if (ph == 4) want_hold = 1'b1;
      add_random(100);
      settle();
    end

    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
